// File: hdl/ljpf_pkg.sv
package ljpf_pkg;

    localparam int LJPF_MAX_PARTICLES = 1024;

    localparam int OP_W      = 2;
    localparam int IDX_W     = 10;
    localparam int D_W       = 25;
    localparam int ACC_W     = 48;
    localparam int CUT_W     = 30;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 48;

    localparam int MUL_W     = 64;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int MUL_DIGIT = 16;

    localparam int FRAC_D      = 20;
    localparam int FRAC_R      = 24;
    localparam int RECIP_SHIFT = 44;

    localparam int SUM_W  = 50;
    localparam int RM2_W  = 29;
    localparam int RM4_W  = 33;
    localparam int RM6_W  = 37;
    localparam int RM12_W = 49;
    localparam int T_W    = 51;
    localparam int PHI_W  = 52;
    localparam int U_W    = 54;
    localparam int DMAG_W = 59;
    localparam int F_W    = 50;
    localparam int FM_W   = 49;
    localparam int DCNT_W = 6;

    localparam logic [CUT_W-1:0]        CUTOFF_SQ_RST = 30'd6553600;
    localparam logic signed [ACC_W-1:0] OFFSET_RST    = -48'sd273757;
    localparam logic [CUT_W-1:0]        R2_CLOSE      = 30'd65536;
    localparam logic [FM_W-1:0]         FM_BIG        = 49'd1 << 48;
    localparam logic [PHI_W-1:0]        PHI_BIG       = 52'd1 << 48;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR = 2'd0,
        OP_ACCUM = 2'd1,
        OP_READ  = 2'd2,
        OP_NOP   = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CUTOFF_SQ     = 1'b0,
        CFG_ENERGY_OFFSET = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_GO,
        S_MUL_WAIT,
        S_DIV,
        S_UPD_RD,
        S_UPD_WR,
        S_POT,
        S_RD_ISSUE,
        S_RD_OUT
    } t_state;

    typedef enum logic [3:0] {
        M_SQ_X,
        M_SQ_Y,
        M_SQ_Z,
        M_RM4,
        M_RM6,
        M_RM12,
        M_DPHI,
        M_F_X,
        M_F_Y,
        M_F_Z
    } t_mstep;

    typedef struct packed {
        logic             hit;
        logic [ACC_W-1:0] val;
    } t_sat;

endpackage

// File: hdl/ljpf_in_if.sv
interface ljpf_in_if;
    logic                              valid;
    logic                              ready;
    logic [ljpf_pkg::OP_W-1:0]         op;
    logic [ljpf_pkg::IDX_W-1:0]        index_i;
    logic [ljpf_pkg::IDX_W-1:0]        index_j;
    logic signed [ljpf_pkg::D_W-1:0]   dx;
    logic signed [ljpf_pkg::D_W-1:0]   dy;
    logic signed [ljpf_pkg::D_W-1:0]   dz;

    modport source (output valid, op, index_i, index_j, dx, dy, dz, input ready);
    modport sink (input valid, op, index_i, index_j, dx, dy, dz, output ready);
endinterface

// File: hdl/ljpf_out_if.sv
interface ljpf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [ljpf_pkg::ACC_W-1:0] force_x;
    logic signed [ljpf_pkg::ACC_W-1:0] force_y;
    logic signed [ljpf_pkg::ACC_W-1:0] force_z;
    logic signed [ljpf_pkg::ACC_W-1:0] total_potential;
    logic                              saturated;

    modport source (output valid, force_x, force_y, force_z, total_potential, saturated,
                    input ready);
    modport sink (input valid, force_x, force_y, force_z, total_potential, saturated,
                  output ready);
endinterface

// File: hdl/ljpf_ram.sv
module ljpf_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/ljpf_mul.sv
module ljpf_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ljpf_pkg::MUL_W-1:0]  i_a,
    input  logic [ljpf_pkg::MUL_W-1:0]  i_b,
    output logic                        o_busy,
    output logic                        o_done,
    output logic [ljpf_pkg::PROD_W-1:0] o_prod
);
    import ljpf_pkg::*;

    localparam int STEPS = MUL_W / MUL_DIGIT;
    localparam int CNT_W = $clog2(STEPS);

    logic [MUL_W-1:0]            r_a;
    logic [MUL_W-1:0]            r_b;
    logic [PROD_W-1:0]           r_acc;
    logic [PROD_W-1:0]           n_acc;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [MUL_W+MUL_DIGIT-1:0]  part;
    logic [MUL_W+MUL_DIGIT:0]    upper;
    logic [PROD_W+MUL_DIGIT:0]   joined;

    always_comb begin
        part   = r_a * r_b[MUL_DIGIT-1:0];
        upper  = (MUL_W + MUL_DIGIT + 1)'(r_acc[PROD_W-1:MUL_W])
               + (MUL_W + MUL_DIGIT + 1)'(part);
        joined = {upper, r_acc[MUL_W-1:0]} >> MUL_DIGIT;
        n_acc  = joined[PROD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= r_b >> MUL_DIGIT;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

// File: hdl/lennard_jones_pair_force_accumulator_core.sv
// Lennard-Jones 12-6 pair force accumulator.
// i_item carries one item per valid/ready handshake: op, two particle indices and the
// separation dx, dy, dz. A clear op zeroes every force entry, the potential and the
// saturation flag; an accumulate op adds the pair force to particle i, subtracts it from
// particle j and adds the shifted pair potential to the total; a read op returns one
// particle's force with the total potential on o_res. Op 3 is taken and dropped.
// The block takes one item at a time; i_item.ready is high only while it is idle.
// All multiplications run through one 64x16 multiplier stepped four times per product,
// and a bit-serial divider forms 1/r^2. An accumulate op ends after r^2 when the pair
// is skipped by the cutoff or at zero distance, skips the divider and later products
// for a very close pair, and runs the full path otherwise.
// Read: S_RD_ISSUE addresses the store, S_RD_OUT loads the output register. Clear: one entry a cycle.
// After reset the same clearing pass runs before i_item.ready rises; configuration
// writes on i_cfg_* are taken at any time.
// A read result sits in the output register until o_res.ready; a stalled receiver holds
// the next read op at its final step, while other ops keep going.
module lennard_jones_pair_force_accumulator_core #(
    parameter int MAX_PARTICLES = ljpf_pkg::LJPF_MAX_PARTICLES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    ljpf_in_if.sink                        i_item,
    ljpf_out_if.source                     o_res,
    input  logic                           i_cfg_we,
    input  logic [ljpf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [ljpf_pkg::CFG_W-1:0]     i_cfg_data
);
    import ljpf_pkg::*;

    localparam int AW    = $clog2(MAX_PARTICLES);
    localparam int ROW_W = 3 * ACC_W;

    t_state                    r_state;
    t_state                    n_state;
    t_mstep                    r_mstep;
    logic [CUT_W-1:0]          r_cut;
    logic signed [ACC_W-1:0]   r_off;
    logic signed [ACC_W-1:0]   r_pot;
    logic                      r_sticky;
    logic [AW-1:0]             r_clr;
    logic [IDX_W-1:0]          r_i;
    logic [IDX_W-1:0]          r_j;
    logic signed [D_W-1:0]     r_dx;
    logic signed [D_W-1:0]     r_dy;
    logic signed [D_W-1:0]     r_dz;
    logic [SUM_W-1:0]          r_sum;
    logic [CUT_W-1:0]          r_r2;
    logic [CUT_W-1:0]          r_rem;
    logic [RM2_W-1:0]          r_q;
    logic [DCNT_W-1:0]         r_dcnt;
    logic [RM4_W-1:0]          r_rm4;
    logic [RM6_W-1:0]          r_rm6;
    logic                      r_tneg;
    logic [T_W-2:0]            r_tmag;
    logic signed [PHI_W-1:0]   r_phi;
    logic [DMAG_W-1:0]         r_dmag;
    logic signed [F_W-1:0]     r_fx;
    logic signed [F_W-1:0]     r_fy;
    logic signed [F_W-1:0]     r_fz;
    logic                      r_side;
    logic                      r_ovalid;
    logic signed [ACC_W-1:0]   r_ofx;
    logic signed [ACC_W-1:0]   r_ofy;
    logic signed [ACC_W-1:0]   r_ofz;
    logic signed [ACC_W-1:0]   r_opot;
    logic                      r_osat;

    logic                      in_ready;
    logic                      accept;
    logic                      out_load;
    logic                      mul_start;
    logic                      mul_busy;
    logic                      mul_done;
    logic [MUL_W-1:0]          mul_a;
    logic [MUL_W-1:0]          mul_b;
    logic [PROD_W-1:0]         mul_prod;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [AW-1:0]             ram_raddr;
    logic [ROW_W-1:0]          ram_wdata;
    logic [ROW_W-1:0]          ram_rdata;

    logic [SUM_W-1:0]          sum_now;
    logic [CUT_W-1:0]          r2_now;
    logic                      r2_zero;
    logic                      r2_skip;
    logic                      r2_close;
    logic [CUT_W:0]            div_shift;
    logic                      div_ge;
    logic [RM12_W-1:0]         rm12_now;
    logic [T_W-1:0]            t_now;
    logic [U_W-1:0]            u_now;
    logic [FM_W-1:0]           fm_now;
    logic signed [D_W-1:0]     cur_d;
    logic signed [F_W-1:0]     f_now;
    logic [IDX_W-1:0]          upd_idx;
    logic                      upd_in_range;
    logic                      rd_in_range;
    t_sat                      sat_x;
    t_sat                      sat_y;
    t_sat                      sat_z;
    logic signed [ACC_W+5:0]   pot_sum;
    logic                      pot_hit;
    logic signed [ACC_W-1:0]   pot_val;

    function automatic logic [D_W-1:0] mag_d(input logic signed [D_W-1:0] v);
        return v[D_W-1] ? D_W'(-v) : D_W'(v);
    endfunction

    function automatic logic signed [F_W-1:0] close_force(input logic signed [D_W-1:0] d);
        logic signed [F_W-1:0] big;
        big = $signed(F_W'(FM_BIG));
        if (d > 0) begin
            return big;
        end else if (d < 0) begin
            return -big;
        end
        return '0;
    endfunction

    function automatic t_sat sat_acc(input logic signed [ACC_W-1:0] old,
                                     input logic signed [F_W-1:0] f, input logic sub);
        logic signed [ACC_W+2:0] s;
        t_sat                    res;
        if (sub) begin
            s = (ACC_W + 3)'(old) - (ACC_W + 3)'(f);
        end else begin
            s = (ACC_W + 3)'(old) + (ACC_W + 3)'(f);
        end
        res.hit = !(s[ACC_W+2:ACC_W-1] == '0 || s[ACC_W+2:ACC_W-1] == '1);
        if (!res.hit) begin
            res.val = s[ACC_W-1:0];
        end else if (s[ACC_W+2]) begin
            res.val = {1'b1, {(ACC_W - 1){1'b0}}};
        end else begin
            res.val = {1'b0, {(ACC_W - 1){1'b1}}};
        end
        return res;
    endfunction

    ljpf_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    ljpf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_PARTICLES),
        .ADDR_W(AW)
    ) u_force_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        sum_now   = r_sum + SUM_W'(mul_prod);
        r2_now    = sum_now[SUM_W-1:FRAC_D];
        r2_zero   = (r2_now == '0);
        r2_skip   = (r2_now >= r_cut);
        r2_close  = (r2_now < R2_CLOSE);
        div_shift = {r_rem, (r_dcnt == DCNT_W'(RECIP_SHIFT))};
        div_ge    = (div_shift >= {1'b0, r_r2});
        rm12_now  = mul_prod[FRAC_R +: RM12_W];
        t_now     = {1'b0, rm12_now, 1'b0} - T_W'(r_rm6);
        u_now     = mul_prod[FRAC_R +: U_W];
        unique case (r_mstep)
            M_F_X:   cur_d = r_dx;
            M_F_Y:   cur_d = r_dy;
            default: cur_d = r_dz;
        endcase
        if ((|mul_prod[PROD_W-1:FRAC_D+FM_W]) || (mul_prod[FRAC_D +: FM_W] > FM_BIG)) begin
            fm_now = FM_BIG;
        end else begin
            fm_now = mul_prod[FRAC_D +: FM_W];
        end
        if (r_tneg != cur_d[D_W-1]) begin
            f_now = -$signed(F_W'(fm_now));
        end else begin
            f_now = $signed(F_W'(fm_now));
        end
        upd_idx      = r_side ? r_j : r_i;
        upd_in_range = (32'(upd_idx) < 32'(MAX_PARTICLES));
        rd_in_range  = (32'(r_i) < 32'(MAX_PARTICLES));
        sat_x        = sat_acc(ram_rdata[ACC_W-1:0], r_fx, r_side);
        sat_y        = sat_acc(ram_rdata[2*ACC_W-1:ACC_W], r_fy, r_side);
        sat_z        = sat_acc(ram_rdata[3*ACC_W-1:2*ACC_W], r_fz, r_side);
        pot_sum      = (ACC_W + 6)'(r_pot) + (ACC_W + 6)'(r_phi) - (ACC_W + 6)'(r_off);
        pot_hit      = !(pot_sum[ACC_W+5:ACC_W-1] == '0 || pot_sum[ACC_W+5:ACC_W-1] == '1);
        if (!pot_hit) begin
            pot_val = pot_sum[ACC_W-1:0];
        end else if (pot_sum[ACC_W+5]) begin
            pot_val = {1'b1, {(ACC_W - 1){1'b0}}};
        end else begin
            pot_val = {1'b0, {(ACC_W - 1){1'b1}}};
        end
    end

    always_comb begin
        unique case (r_mstep)
            M_SQ_X: begin
                mul_a = MUL_W'(mag_d(r_dx));
                mul_b = MUL_W'(mag_d(r_dx));
            end
            M_SQ_Y: begin
                mul_a = MUL_W'(mag_d(r_dy));
                mul_b = MUL_W'(mag_d(r_dy));
            end
            M_SQ_Z: begin
                mul_a = MUL_W'(mag_d(r_dz));
                mul_b = MUL_W'(mag_d(r_dz));
            end
            M_RM4: begin
                mul_a = MUL_W'(r_q);
                mul_b = MUL_W'(r_q);
            end
            M_RM6: begin
                mul_a = MUL_W'(r_rm4);
                mul_b = MUL_W'(r_q);
            end
            M_RM12: begin
                mul_a = MUL_W'(r_rm6);
                mul_b = MUL_W'(r_rm6);
            end
            M_DPHI: begin
                mul_a = MUL_W'(r_tmag);
                mul_b = MUL_W'(r_q);
            end
            M_F_X: begin
                mul_a = MUL_W'(r_dmag);
                mul_b = MUL_W'(mag_d(r_dx));
            end
            M_F_Y: begin
                mul_a = MUL_W'(r_dmag);
                mul_b = MUL_W'(mag_d(r_dy));
            end
            M_F_Z: begin
                mul_a = MUL_W'(r_dmag);
                mul_b = MUL_W'(mag_d(r_dz));
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        in_ready  = 1'b0;
        mul_start = 1'b0;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = AW'(upd_idx);
        ram_wdata = {sat_z.val, sat_y.val, sat_x.val};
        ram_raddr = AW'(upd_idx);
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                if (r_clr == AW'(MAX_PARTICLES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_item.valid) begin
                    unique case (t_op'(i_item.op))
                        OP_CLEAR: n_state = S_CLEAR;
                        OP_ACCUM: n_state = S_MUL_GO;
                        OP_READ:  n_state = S_RD_ISSUE;
                        OP_NOP:   n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL_GO: begin
                mul_start = 1'b1;
                n_state   = S_MUL_WAIT;
            end
            S_MUL_WAIT: begin
                if (mul_done) begin
                    priority case (r_mstep)
                        M_SQ_Z: begin
                            priority if (r2_zero || r2_skip) begin
                                n_state = S_IDLE;
                            end else if (r2_close) begin
                                n_state = S_UPD_RD;
                            end else begin
                                n_state = S_DIV;
                            end
                        end
                        M_F_Z:   n_state = S_UPD_RD;
                        default: n_state = S_MUL_GO;
                    endcase
                end
            end
            S_DIV: begin
                if (r_dcnt == '0) begin
                    n_state = S_MUL_GO;
                end
            end
            S_UPD_RD: begin
                if (upd_in_range) begin
                    n_state = S_UPD_WR;
                end else if (r_side) begin
                    n_state = S_POT;
                end
            end
            S_UPD_WR: begin
                ram_we  = 1'b1;
                n_state = r_side ? S_POT : S_UPD_RD;
            end
            S_POT: begin
                n_state = S_IDLE;
            end
            S_RD_ISSUE: begin
                ram_raddr = AW'(r_i);
                n_state   = S_RD_OUT;
            end
            S_RD_OUT: begin
                ram_raddr = AW'(r_i);
                if (!r_ovalid || o_res.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign accept = in_ready && i_item.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_pot    <= '0;
            r_sticky <= 1'b0;
            r_cut    <= CUTOFF_SQ_RST;
            r_off    <= OFFSET_RST;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_CUTOFF_SQ:     r_cut <= i_cfg_data[CUT_W-1:0];
                    CFG_ENERGY_OFFSET: r_off <= $signed(i_cfg_data[ACC_W-1:0]);
                endcase
            end
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (accept && t_op'(i_item.op) == OP_CLEAR) begin
                r_clr    <= '0;
                r_pot    <= '0;
                r_sticky <= 1'b0;
            end
            if (r_state == S_MUL_WAIT && mul_done && r_mstep == M_SQ_Z && r2_zero) begin
                r_sticky <= 1'b1;
            end
            if (r_state == S_UPD_WR && (sat_x.hit || sat_y.hit || sat_z.hit)) begin
                r_sticky <= 1'b1;
            end
            if (r_state == S_POT) begin
                r_pot <= pot_val;
                if (pot_hit) begin
                    r_sticky <= 1'b1;
                end
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_i     <= i_item.index_i;
            r_j     <= i_item.index_j;
            r_dx    <= i_item.dx;
            r_dy    <= i_item.dy;
            r_dz    <= i_item.dz;
            r_mstep <= M_SQ_X;
            r_sum   <= '0;
            r_side  <= 1'b0;
        end
        if (r_state == S_MUL_WAIT && mul_done) begin
            r_mstep <= t_mstep'(r_mstep + 1'b1);
            unique case (r_mstep)
                M_SQ_X, M_SQ_Y: begin
                    r_sum <= sum_now;
                end
                M_SQ_Z: begin
                    r_r2   <= r2_now;
                    r_rem  <= '0;
                    r_q    <= '0;
                    r_dcnt <= DCNT_W'(RECIP_SHIFT);
                    r_phi  <= $signed(PHI_BIG);
                    r_fx   <= close_force(r_dx);
                    r_fy   <= close_force(r_dy);
                    r_fz   <= close_force(r_dz);
                end
                M_RM4: r_rm4 <= mul_prod[FRAC_R +: RM4_W];
                M_RM6: r_rm6 <= mul_prod[FRAC_R +: RM6_W];
                M_RM12: begin
                    r_tneg <= t_now[T_W-1];
                    r_tmag <= t_now[T_W-1] ? (T_W - 1)'(-t_now) : t_now[T_W-2:0];
                    r_phi  <= $signed((PHI_W'(rm12_now) - PHI_W'(r_rm6)) << 2);
                end
                M_DPHI: r_dmag <= (DMAG_W'(u_now) << 4) + (DMAG_W'(u_now) << 3);
                M_F_X:  r_fx <= f_now;
                M_F_Y:  r_fy <= f_now;
                M_F_Z:  r_fz <= f_now;
                default: r_sum <= r_sum;
            endcase
        end
        if (r_state == S_DIV) begin
            r_dcnt <= r_dcnt - 1'b1;
            r_q    <= {r_q[RM2_W-2:0], div_ge};
            if (div_ge) begin
                r_rem <= CUT_W'(div_shift - {1'b0, r_r2});
            end else begin
                r_rem <= div_shift[CUT_W-1:0];
            end
            if (r_dcnt == '0) begin
                r_mstep <= M_RM4;
            end
        end
        if ((r_state == S_UPD_RD && !upd_in_range) || r_state == S_UPD_WR) begin
            r_side <= 1'b1;
        end
        if (out_load) begin
            r_ofx  <= rd_in_range ? $signed(ram_rdata[ACC_W-1:0]) : '0;
            r_ofy  <= rd_in_range ? $signed(ram_rdata[2*ACC_W-1:ACC_W]) : '0;
            r_ofz  <= rd_in_range ? $signed(ram_rdata[3*ACC_W-1:2*ACC_W]) : '0;
            r_opot <= r_pot;
            r_osat <= r_sticky;
        end
    end

    assign i_item.ready          = in_ready;
    assign o_res.valid           = r_ovalid;
    assign o_res.force_x         = r_ofx;
    assign o_res.force_y         = r_ofy;
    assign o_res.force_z         = r_ofz;
    assign o_res.total_potential = r_opot;
    assign o_res.saturated       = r_osat;

    a_ready_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready |-> !mul_busy)
        else $error("item taken while multiplier busy");

    a_ram_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_UPD_WR))
        else $error("force store written outside clear or update");

    a_mul_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL_WAIT))
        else $error("product finished outside the wait step");

    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_r2 >= R2_CLOSE && r_r2 < r_cut))
        else $error("reciprocal started on a skipped pair");
endmodule
